@@ design/ttlin_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlin_pkg: thermistor linearizer shared types and tables
// Breakpoint curve, per-segment slope constants and the item queue entry type.
// ----------------------------------------------------------------------------
package ttlin_pkg;

  localparam int TABLE_POINTS = 20;
  localparam int SEGMENTS     = TABLE_POINTS - 1;
  localparam int SEG_W        = $clog2(SEGMENTS);
  localparam int OHM_W        = 17;
  localparam int DX_W         = 16;
  localparam int SR_W         = 16;

  // breakpoint resistances in ohms, rising
  localparam logic [OHM_W-1:0] BP_OHMS [TABLE_POINTS] = '{
    17'd177,   17'd241,   17'd332,   17'd467,   17'd667,
    17'd973,   17'd1188,  17'd1459,  17'd1802,  17'd2238,
    17'd2796,  17'd3520,  17'd4450,  17'd5670,  17'd7280,
    17'd9420,  17'd16180, 17'd28680, 17'd52700, 17'd100000
  };

  // segment width in ohms
  localparam logic [DX_W-1:0] SEG_DX [SEGMENTS] = '{
    16'd64,   16'd91,   16'd135,  16'd200,   16'd306,
    16'd215,  16'd271,  16'd343,  16'd436,   16'd558,
    16'd724,  16'd930,  16'd1220, 16'd1610,  16'd2140,
    16'd6760, 16'd12500, 16'd24020, 16'd47300
  };

  // temperature at the lower resistance end of each segment
  localparam logic signed [7:0] SEG_Y1 [SEGMENTS] = '{
    8'sd100, 8'sd90, 8'sd80, 8'sd70, 8'sd60,
    8'sd50,  8'sd45, 8'sd40, 8'sd35, 8'sd30,
    8'sd25,  8'sd20, 8'sd15, 8'sd10, 8'sd5,
    8'sd0,   -8'sd10, -8'sd20, -8'sd30
  };

  // temperature step across each segment
  localparam logic signed [7:0] SEG_DY [SEGMENTS] = '{
    -8'sd10, -8'sd10, -8'sd10, -8'sd10, -8'sd10,
    -8'sd5,  -8'sd5,  -8'sd5,  -8'sd5,  -8'sd5,
    -8'sd5,  -8'sd5,  -8'sd5,  -8'sd5,  -8'sd5,
    -8'sd10, -8'sd10, -8'sd10, -8'sd10
  };

  // classification of one item as it crosses the queue
  typedef struct packed {
    logic             oor;
    logic [SEG_W-1:0] seg;
  } class_t;

endpackage

@@ design/ttlin_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlin_front: resistance divider and segment classifier
// Pipelined restoring division, one quotient bit per stage, then breakpoint
// compare to pick the segment.
// ----------------------------------------------------------------------------
module ttlin_front import ttlin_pkg::*; #(
  parameter int ADC_BITS          = 12,
  parameter int RES_FRACTION_BITS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic [ADC_BITS-1:0]                code_i,
  input  logic [SR_W-1:0]                    sr_i,
  output logic                               valid_o,
  output class_t                             cls_o,
  output logic [OHM_W+RES_FRACTION_BITS-1:0] res_o
);

  localparam int NW = SR_W + ADC_BITS + RES_FRACTION_BITS;
  localparam int DW = ADC_BITS + 1;
  localparam int RW = OHM_W + RES_FRACTION_BITS;

  logic          dv_q  [NW+1];
  logic [DW-1:0] rem_q [NW+1];
  logic [NW-1:0] n_q   [NW+1];
  logic [DW-1:0] den_q [NW+1];

  // input stage: numerator and divisor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else begin
      dv_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q[0]   <= (NW'(sr_i) * NW'(code_i)) << RES_FRACTION_BITS;
    den_q[0] <= DW'(1 << ADC_BITS) - DW'(code_i);
    rem_q[0] <= '0;
  end

  // one quotient bit per stage
  for (genvar s = 0; s < NW; s++) begin : g_div
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_d;

    always_comb begin
      trial = {rem_q[s], n_q[s][NW-1]};
      ge    = trial >= {1'b0, den_q[s]};
      rem_d = ge ? DW'(trial - {1'b0, den_q[s]}) : trial[DW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[s+1] <= 1'b0;
      end else begin
        dv_q[s+1] <= dv_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= rem_d;
      n_q[s+1]   <= {n_q[s][NW-2:0], ge};
      den_q[s+1] <= den_q[s];
    end
  end

  // breakpoint compare and segment pick
  logic [TABLE_POINTS-1:0] gt;
  class_t                  cls_d;

  always_comb begin
    for (int i = 0; i < TABLE_POINTS; i++) begin
      gt[i] = n_q[NW] > (NW'(BP_OHMS[i]) << RES_FRACTION_BITS);
    end
    cls_d.seg = '0;
    for (int i = 0; i < SEGMENTS; i++) begin
      if (gt[i] && !gt[i+1]) begin
        cls_d.seg = SEG_W'(i);
      end
    end
    cls_d.oor = !gt[0] || gt[TABLE_POINTS-1];
  end

  logic   valid_q;
  class_t cls_q;
  logic [RW-1:0] res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= dv_q[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q <= cls_d;
    res_q <= n_q[NW][RW-1:0];
  end

  assign valid_o = valid_q;
  assign cls_o   = cls_q;
  assign res_o   = res_q;

endmodule

@@ design/ttlin_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlin_queue: two-entry item queue
// Decouples the classifier from the interpolator.
// ----------------------------------------------------------------------------
module ttlin_queue import ttlin_pkg::*; #(
  parameter int RES_FRACTION_BITS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  input  class_t                             cls_i,
  input  logic [OHM_W+RES_FRACTION_BITS-1:0] res_i,
  output logic                               pop_o,
  output class_t                             cls_o,
  output logic [OHM_W+RES_FRACTION_BITS-1:0] res_o,
  output logic                               full_o
);

  localparam int RW = OHM_W + RES_FRACTION_BITS;
  localparam int EW = RW + $bits(class_t);

  logic [EW-1:0] mem [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q, cnt_d;
  logic          pop;

  // back end always drains
  assign pop = cnt_q != 2'd0;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= {cls_i, res_i};
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  assign pop_o  = pop;
  assign cls_o  = class_t'(mem[rd_ptr_q][EW-1:RW]);
  assign res_o  = mem[rd_ptr_q][RW-1:0];
  assign full_o = cnt_q == 2'd2;

endmodule

@@ design/ttlin_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlin_back: segment interpolator
// Builds the interpolation numerator, then divides by the segment width
// with a seven-stage restoring divider and applies the sign.
// ----------------------------------------------------------------------------
module ttlin_back import ttlin_pkg::*; #(
  parameter int RES_FRACTION_BITS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  class_t                             cls_i,
  input  logic [OHM_W+RES_FRACTION_BITS-1:0] res_i,
  output logic                               done_o,
  output logic signed [7:0]                  temp_o,
  output logic                               oor_o
);

  localparam int RW  = OHM_W + RES_FRACTION_BITS;
  localparam int DW  = DX_W + RES_FRACTION_BITS;
  localparam int NMW = DW + 7;
  localparam int SW  = NMW + 1;
  localparam int QS  = 7;

  // stage 1: offset into segment and scaled width
  logic          v1_q, oor1_q;
  logic [DW-1:0] den1_q, off1_q;
  logic signed [7:0] y1_q, dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    oor1_q <= cls_i.oor;
    den1_q <= DW'(SEG_DX[cls_i.seg]) << RES_FRACTION_BITS;
    off1_q <= DW'(res_i - (RW'(BP_OHMS[cls_i.seg]) << RES_FRACTION_BITS));
    y1_q   <= SEG_Y1[cls_i.seg];
    dy_q   <= SEG_DY[cls_i.seg];
  end

  // stage 2: the two products
  logic              v2_q, oor2_q;
  logic [DW-1:0]     den2_q;
  logic signed [SW-1:0] p1_q, p2_q;
  logic signed [SW-1:0] den_s, off_s, y1_s, dy_s;

  always_comb begin
    den_s = $signed(SW'(den1_q));
    off_s = $signed(SW'(off1_q));
    y1_s  = SW'(y1_q);
    dy_s  = SW'(dy_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    oor2_q <= oor1_q;
    den2_q <= den1_q;
    p1_q   <= y1_s * den_s;
    p2_q   <= dy_s * off_s;
  end

  // stage 3: numerator sign and magnitude
  logic signed [SW-1:0] num;
  logic                 vq_q   [QS+1];
  logic                 oorq_q [QS+1];
  logic                 negq_q [QS+1];
  logic [NMW-1:0]       magq_q [QS+1];
  logic [DW-1:0]        denq_q [QS+1];
  logic [QS-1:0]        quoq_q [QS+1];

  assign num = p1_q + p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vq_q[0] <= 1'b0;
    end else begin
      vq_q[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    oorq_q[0] <= oor2_q;
    negq_q[0] <= num[SW-1];
    magq_q[0] <= num[SW-1] ? NMW'(-num) : num[NMW-1:0];
    denq_q[0] <= den2_q;
    quoq_q[0] <= '0;
  end

  // restoring division, quotient below 128
  for (genvar s = 0; s < QS; s++) begin : g_quo
    localparam int K = QS - 1 - s;
    logic [NMW-1:0] sub;
    logic           ge;

    always_comb begin
      sub = NMW'(denq_q[s]) << K;
      ge  = magq_q[s] >= sub;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vq_q[s+1] <= 1'b0;
      end else begin
        vq_q[s+1] <= vq_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      oorq_q[s+1] <= oorq_q[s];
      negq_q[s+1] <= negq_q[s];
      denq_q[s+1] <= denq_q[s];
      magq_q[s+1] <= ge ? magq_q[s] - sub : magq_q[s];
      quoq_q[s+1] <= quoq_q[s] | (QS'(ge) << K);
    end
  end

  // output register with sign and range fixup
  logic              done_q, oor_q;
  logic signed [7:0] temp_q, temp_d;
  logic [7:0]        mag8;

  always_comb begin
    mag8 = {1'b0, quoq_q[QS]};
    if (oorq_q[QS]) begin
      temp_d = '0;
    end else if (negq_q[QS]) begin
      temp_d = $signed(-mag8);
    end else begin
      temp_d = $signed(mag8);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vq_q[QS];
    end
  end

  always_ff @(posedge clk_i) begin
    temp_q <= temp_d;
    oor_q  <= oorq_q[QS];
  end

  assign done_o = done_q;
  assign temp_o = temp_q;
  assign oor_o  = oor_q;

endmodule

@@ design/thermistor_temperature_linearizer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermistor_temperature_linearizer_top: ADC code to temperature
// Channel  | direction | handshake            | payload
// input    | in        | start_i / busy_o     | adc_code_i
// result   | out       | done_o (strobe)      | temperature_o, out_of_range_o
// config   | in        | series_resistance_we_i | series_resistance_i
//
// One item accepted per cycle while busy_o is low; each item passes the
// one-bit-per-stage resistance divider, the segment classifier, the queue
// and the interpolator in that order before done_o rises.
// Reset clears all valid flags and loads series resistance 1000.
// The result strobe lasts one cycle; the receiver cannot stall, so the
// queue always drains and busy_o stays low in normal operation.
// ----------------------------------------------------------------------------
module thermistor_temperature_linearizer_top import ttlin_pkg::*; #(
  parameter int ADC_BITS          = 12,
  parameter int RES_FRACTION_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [ADC_BITS-1:0]   adc_code_i,
  input  logic                  series_resistance_we_i,
  input  logic [SR_W-1:0]       series_resistance_i,
  output logic                  done_o,
  output logic signed [7:0]     temperature_o,
  output logic                  out_of_range_o
);

  localparam int RW = OHM_W + RES_FRACTION_BITS;

  logic [SR_W-1:0] sr_q;
  logic            accept;
  logic            f_valid, q_pop, q_full;
  class_t          f_cls, q_cls;
  logic [RW-1:0]   f_res, q_res;

  // series resistance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q <= SR_W'(1000);
    end else if (series_resistance_we_i) begin
      sr_q <= series_resistance_i;
    end
  end

  assign accept = start_i && !busy_o;
  assign busy_o = q_full;

  ttlin_front #(
    .ADC_BITS         (ADC_BITS),
    .RES_FRACTION_BITS(RES_FRACTION_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(accept),
    .code_i (adc_code_i),
    .sr_i   (sr_q),
    .valid_o(f_valid),
    .cls_o  (f_cls),
    .res_o  (f_res)
  );

  ttlin_queue #(
    .RES_FRACTION_BITS(RES_FRACTION_BITS)
  ) u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(f_valid),
    .cls_i (f_cls),
    .res_i (f_res),
    .pop_o (q_pop),
    .cls_o (q_cls),
    .res_o (q_res),
    .full_o(q_full)
  );

  ttlin_back #(
    .RES_FRACTION_BITS(RES_FRACTION_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(q_pop),
    .cls_i  (q_cls),
    .res_i  (q_res),
    .done_o (done_o),
    .temp_o (temperature_o),
    .oor_o  (out_of_range_o)
  );

endmodule

@@ design/ttlin_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlin_checker: port-level checks for the linearizer
// Result range and reset behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module ttlin_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              busy_o,
  input logic              done_o,
  input logic signed [7:0] temperature_o,
  input logic              out_of_range_o
);

  // out of range items carry zero temperature
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_of_range_o |-> temperature_o == 8'sd0)
    else $error("out of range item with nonzero temperature");

  // in range items stay within the curve span
  a_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !out_of_range_o |-> temperature_o >= -8'sd40 && temperature_o <= 8'sd100)
    else $error("temperature outside curve span");

  // the queue always drains, so the input never stalls
  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("input stalled");

  // no item strobes right after reset
  a_reset_quiet: assert property (@(posedge clk_i)
    rst_ni && $past(!rst_ni) |-> !done_o)
    else $error("result strobe right after reset");

endmodule

bind thermistor_temperature_linearizer_top ttlin_checker u_ttlin_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .temperature_o (temperature_o),
  .out_of_range_o(out_of_range_o)
);
